>>> rtl/rotation_matrix_to_quaternion_assert.svh
// assertion macros used by rotation_matrix_to_quaternion.sv
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// checked only while out of reset
`define RMQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rmq assertion failed");

// checked at every edge, reset included
`define RMQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rmq assertion failed");

`endif

>>> rtl/rmq_pkg.sv
package rmq_pkg;

  localparam int FRAC_BITS_DEF = 14;
  // quotient bits kept before saturation to 16 bits
  localparam int QUO_BITS = 17;
  localparam int MAG_BITS = 17;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } br_t;

  // payload riding beside the square root
  typedef struct packed {
    br_t                        br;
    logic [2:0]                 neg;
    logic [2:0][MAG_BITS-1:0]   mag;
  } side1_t;

  // payload riding beside the dividers
  typedef struct packed {
    br_t         br;
    logic [15:0] dom;
    logic        degen;
    logic [2:0]  ovf;
    logic [2:0]  neg;
  } side2_t;

endpackage

>>> rtl/rotation_matrix_to_quaternion.sv
// rotation matrix to unit quaternion, shepperd branch selection, fixed point
// in_*  : one 3x3 matrix per beat, nine signed entries with FRAC_BITS fraction bits
// out_* : one quaternion per beat, w x y z saturated to 16 bits signed,
//         plus branch code and degenerate flag in tuser
// the pipe runs stage a, square root, stage b, dividers and output register;
// RW is the root width of the square root (17 at FRAC_BITS = 14); one root
// bit and one quotient bit resolve per register stage; throughput is one
// matrix per cycle unless the pipe holds, each stage taking a beat per cycle
// when out_tready is low with a result waiting, the whole pipe holds, and
// in_tready drops in the same cycle; nothing is dropped or repeated
// while no result waits the pipe keeps moving, so bubbles drain out
// synchronous active-low reset clears all valid bits; data regs keep junk
// a zero root gives all-zero components with the degenerate flag set
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // m00 m01 m02 m10 m11 m12 m20 m21 m22, 16 bits each from bit 0 up
  input  logic [143:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // quat_w quat_x quat_y quat_z, 16 bits each from bit 0 up
  output logic [63:0]   out_tdata,
  // branch_taken [1:0], degenerate [2]
  output logic [2:0]    out_tuser
);
  import rmq_pkg::*;

  // argument magnitude width, root width, division widths
  localparam int AU = $clog2((2 ** FRAC_BITS) + 98305);
  localparam int AS = AU + 2;
  localparam int XW = AU + FRAC_BITS + 2;
  localparam int RW = (XW + 1) / 2;
  localparam int XP = 2 * RW;
  localparam int DW = RW + 1;
  localparam int NW0 = MAG_BITS + FRAC_BITS + 1;
  localparam int NW = ((NW0 > RW) ? NW0 : RW) + 1;
  localparam int QW = QUO_BITS;
  localparam int CW = (NW > DW + QW) ? NW : DW + QW;
  localparam logic signed [AS-1:0] ONE_S = AS'(1) << FRAC_BITS;

  // output register valid, the only place that can hold the pipe
  logic out_valid_r;

  logic en;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // ---------------- stage a: branch pick, argument, numerators ----------
  logic signed [15:0] m [9];
  for (genvar gi = 0; gi < 9; gi++) begin : g_unpack
    assign m[gi] = in_tdata[16*gi +: 16];
  end

  logic                      valid_a_r;
  logic [AU-1:0]             arg_r, arg_nxt;
  side1_t                    side_a_r, side_a_nxt;

  always_comb begin
    logic signed [AS-1:0]       e00, e11, e22;
    logic signed [AS-1:0]       trace, arg;
    logic signed [MAG_BITS-1:0] n [3];
    logic signed [MAG_BITS-1:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
    e00    = AS'(m[0]);
    e11    = AS'(m[4]);
    e22    = AS'(m[8]);
    trace  = e00 + e11 + e22;
    d21_12 = MAG_BITS'(m[7]) - MAG_BITS'(m[5]);
    d02_20 = MAG_BITS'(m[2]) - MAG_BITS'(m[6]);
    d10_01 = MAG_BITS'(m[3]) - MAG_BITS'(m[1]);
    s01_10 = MAG_BITS'(m[1]) + MAG_BITS'(m[3]);
    s02_20 = MAG_BITS'(m[2]) + MAG_BITS'(m[6]);
    s12_21 = MAG_BITS'(m[5]) + MAG_BITS'(m[7]);
    if (trace > 0) begin
      side_a_nxt.br = BR_TRACE;
      arg  = trace + ONE_S;
      n[0] = d21_12; n[1] = d02_20; n[2] = d10_01;
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      side_a_nxt.br = BR_X;
      arg  = ONE_S + e00 - e11 - e22;
      n[0] = d21_12; n[1] = s01_10; n[2] = s02_20;
    end else if (m[4] > m[8]) begin
      side_a_nxt.br = BR_Y;
      arg  = ONE_S - e00 + e11 - e22;
      n[0] = d02_20; n[1] = s01_10; n[2] = s12_21;
    end else begin
      side_a_nxt.br = BR_Z;
      arg  = ONE_S - e00 - e11 + e22;
      n[0] = d10_01; n[1] = s02_20; n[2] = s12_21;
    end
    // negative argument clamps to zero
    arg_nxt = arg[AS-1] ? '0 : arg[AU-1:0];
    for (int k = 0; k < 3; k++) begin
      side_a_nxt.neg[k] = n[k][MAG_BITS-1];
      side_a_nxt.mag[k] = n[k][MAG_BITS-1] ? MAG_BITS'(-n[k]) : MAG_BITS'(n[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (en) begin
      valid_a_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      arg_r    <= arg_nxt;
      side_a_r <= side_a_nxt;
    end
  end

  // ---------------- square root of arg << (FRAC_BITS + 2) ---------------
  logic [RW-1:0] root;

  rmq_sqrt #(
    .RW (RW)
  ) u_sqrt (
    .clk    (clk),
    .en     (en),
    .x_i    (XP'(arg_r) << (FRAC_BITS + 2)),
    .root_o (root)
  );

  logic   v1_r    [RW];
  side1_t side1_r [RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < RW; k++) v1_r[k] <= 1'b0;
    end else if (en) begin
      v1_r[0] <= valid_a_r;
      for (int k = 1; k < RW; k++) v1_r[k] <= v1_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r[0] <= side_a_r;
      for (int k = 1; k < RW; k++) side1_r[k] <= side1_r[k-1];
    end
  end

  // ---------------- stage b: dominant part, division operands -----------
  logic          valid_b_r;
  side2_t        side_b_r, side_b_nxt;
  logic [NW-1:0] num_r [3];
  logic [NW-1:0] num_nxt [3];
  logic [DW-1:0] den_r, den_nxt;

  always_comb begin
    logic [RW:0] dom_full;
    side1_t      s1;
    s1       = side1_r[RW-1];
    dom_full = ((RW+1)'(root) + (RW+1)'(2)) >> 2;
    side_b_nxt.br    = s1.br;
    side_b_nxt.neg   = s1.neg;
    side_b_nxt.degen = (root == '0);
    side_b_nxt.dom   = (dom_full > (RW+1)'(32767)) ? 16'h7fff : dom_full[15:0];
    // rounded quotient is floor((mag << (F+1) + s) / 2s)
    den_nxt = DW'(root) << 1;
    for (int k = 0; k < 3; k++) begin
      num_nxt[k] = (NW'(s1.mag[k]) << (FRAC_BITS + 1)) + NW'(root);
      side_b_nxt.ovf[k] = CW'(num_nxt[k]) >= (CW'(den_nxt) << QW);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else if (en) begin
      valid_b_r <= v1_r[RW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_b_r <= side_b_nxt;
      den_r    <= den_nxt;
      for (int k = 0; k < 3; k++) num_r[k] <= num_nxt[k];
    end
  end

  // ---------------- three dividers sharing the denominator --------------
  logic [QW-1:0] quo [3];

  for (genvar gi = 0; gi < 3; gi++) begin : g_div
    rmq_div #(
      .NW (NW),
      .DW (DW)
    ) u_div (
      .clk   (clk),
      .en    (en),
      .num_i (num_r[gi]),
      .den_i (den_r),
      .quo_o (quo[gi])
    );
  end

  logic   v2_r    [QW];
  side2_t side2_r [QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW; k++) v2_r[k] <= 1'b0;
    end else if (en) begin
      v2_r[0] <= valid_b_r;
      for (int k = 1; k < QW; k++) v2_r[k] <= v2_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2_r[0] <= side_b_r;
      for (int k = 1; k < QW; k++) side2_r[k] <= side2_r[k-1];
    end
  end

  // ---------------- output stage: sign, saturate, place ----------------
  logic [63:0] out_tdata_r, out_tdata_nxt;
  logic [2:0]  out_tuser_r, out_tuser_nxt;

  always_comb begin
    side2_t      s2;
    logic [15:0] c [3];
    s2 = side2_r[QW-1];
    for (int k = 0; k < 3; k++) begin
      if (s2.degen) begin
        c[k] = '0;
      end else if (!s2.neg[k]) begin
        c[k] = (s2.ovf[k] || quo[k] > QW'(32767)) ? 16'h7fff : quo[k][15:0];
      end else begin
        c[k] = (s2.ovf[k] || quo[k] > QW'(32768)) ? 16'h8000 : 16'(-quo[k]);
      end
    end
    case (s2.br)
      BR_TRACE: out_tdata_nxt = {c[2], c[1], c[0], s2.dom};
      BR_X:     out_tdata_nxt = {c[2], c[1], s2.dom, c[0]};
      BR_Y:     out_tdata_nxt = {c[2], s2.dom, c[1], c[0]};
      default:  out_tdata_nxt = {s2.dom, c[2], c[1], c[0]};
    endcase
    out_tuser_nxt = {s2.degen, s2.br};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v2_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------- checks ----------------
  `include "rotation_matrix_to_quaternion_assert.svh"

  // degenerate root forces every component to zero
  `RMQ_ASSERT(a_degen_zero, out_tvalid && out_tuser[2] |-> out_tdata == 64'd0)
  // dominant component is never negative
  `RMQ_ASSERT(a_dom_w_pos, out_tvalid && out_tuser[1:0] == BR_TRACE |-> !out_tdata[15])
  `RMQ_ASSERT(a_dom_z_pos, out_tvalid && out_tuser[1:0] == BR_Z |-> !out_tdata[63])
  // a waiting result freezes the input side
  `RMQ_ASSERT(a_stall_in, out_tvalid && !out_tready |-> !in_tready)
  // reset empties the output register
  `RMQ_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid)

endmodule

>>> rtl/rmq_sqrt.sv
module rmq_sqrt #(
  parameter int RW = 17
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] x_i,
  output logic [RW-1:0]   root_o
);
  import rmq_pkg::*;

  localparam int XP = 2 * RW;

  logic [RW:0]   rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [XP-1:0] x_r    [RW];

  // one root bit per stage
  for (genvar gi = 0; gi < RW; gi++) begin : g_stage
    logic [RW:0]   p_rem;
    logic [RW-1:0] p_root;
    logic [XP-1:0] p_x;
    logic [RW+2:0] cur;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          ge;

    if (gi == 0) begin : g_first
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_x    = x_i;
    end else begin : g_next
      assign p_rem  = rem_r[gi-1];
      assign p_root = root_r[gi-1];
      assign p_x    = x_r[gi-1];
    end

    always_comb begin
      cur   = {p_rem, p_x[XP-1:XP-2]};
      trial = (RW+3)'({p_root, 2'b01});
      ge    = cur >= trial;
      diff  = cur - trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[gi]  <= ge ? diff[RW:0] : cur[RW:0];
        root_r[gi] <= {p_root[RW-2:0], ge};
        x_r[gi]    <= p_x << 2;
      end
    end
  end

  assign root_o = root_r[RW-1];

endmodule

>>> rtl/rmq_div.sv
module rmq_div #(
  parameter int NW = 33,
  parameter int DW = 18
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [NW-1:0]                num_i,
  input  logic [DW-1:0]                den_i,
  output logic [rmq_pkg::QUO_BITS-1:0] quo_o
);
  import rmq_pkg::*;

  localparam int QW = QUO_BITS;
  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [CW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];

  // restoring division, one quotient bit per stage, msb first
  for (genvar gi = 0; gi < QW; gi++) begin : g_stage
    logic [CW-1:0] p_rem;
    logic [DW-1:0] p_den;
    logic [QW-1:0] p_quo;
    logic [CW-1:0] sh;
    logic          ge;

    if (gi == 0) begin : g_first
      assign p_rem = CW'(num_i);
      assign p_den = den_i;
      assign p_quo = '0;
    end else begin : g_next
      assign p_rem = rem_r[gi-1];
      assign p_den = den_r[gi-1];
      assign p_quo = quo_r[gi-1];
    end

    always_comb begin
      sh = CW'(p_den) << (QW - 1 - gi);
      ge = p_rem >= sh;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[gi] <= ge ? p_rem - sh : p_rem;
        den_r[gi] <= p_den;
        quo_r[gi] <= {p_quo[QW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_r[QW-1];

endmodule
